// ===== hw/rtl/bda_pkg.sv =====
// constants shared by the binary to decimal ascii core
// no dependencies
package bda_pkg;

   localparam int unsigned DIGIT_BITS = 4;
   localparam int unsigned CHAR_BITS = 6;
   localparam int unsigned FIELD_BITS = 32;

   localparam logic [DIGIT_BITS-1:0] DABBLE_LIMIT = 4'd5;
   localparam logic [DIGIT_BITS-1:0] DABBLE_ADD = 4'd3;
   localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;

   typedef logic [CHAR_BITS-1:0] char_type;

endpackage

// ===== hw/rtl/bda_if.sv =====
// valid/ready channel interfaces for the request and response sides
// depends on bda_pkg
interface bda_req_if;
   logic valid;
   logic ready;
   logic [bda_pkg::FIELD_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface bda_rsp_if;
   logic valid;
   logic ready;
   bda_pkg::char_type digit_char;
   logic last;

   modport source (output valid, output digit_char, output last, input ready);
   modport sink (input valid, input digit_char, input last, output ready);
endinterface

// ===== hw/rtl/bda_dabble_stage.sv =====
// one shift-and-add-3 step of the binary to bcd pipeline
// depends on bda_pkg
module bda_dabble_stage #(
   parameter int unsigned VALUE_BITS = 32,
   parameter int unsigned BCD_BITS = 40
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [BCD_BITS-1:0]   in_bcd,
   input  logic [VALUE_BITS-1:0] in_bin,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [BCD_BITS-1:0]   out_bcd,
   output logic [VALUE_BITS-1:0] out_bin
);
   localparam int unsigned DIGITS = BCD_BITS / bda_pkg::DIGIT_BITS;

   logic                  valid_ff;
   logic [BCD_BITS-1:0]   bcd_ff;
   logic [BCD_BITS-1:0]   bcd_in;
   logic [VALUE_BITS-1:0] bin_ff;
   logic [VALUE_BITS-1:0] bin_in;
   logic [BCD_BITS-1:0]   adj;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (in_bcd[i*4 +: 4] >= bda_pkg::DABBLE_LIMIT) begin
            adj[i*4 +: 4] = in_bcd[i*4 +: 4] + bda_pkg::DABBLE_ADD;
         end else begin
            adj[i*4 +: 4] = in_bcd[i*4 +: 4];
         end
      end
      bcd_in = {adj[BCD_BITS-2:0], in_bin[VALUE_BITS-1]};
      bin_in = {in_bin[VALUE_BITS-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         bcd_ff <= bcd_in;
         bin_ff <= bin_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_bcd = bcd_ff;
   assign out_bin = bin_ff;
endmodule

// ===== hw/rtl/bda_serializer.sv =====
// sends the bcd digits out one char per beat, leading zeros dropped
// depends on bda_pkg and bda_if
module bda_serializer #(
   parameter int unsigned BCD_BITS = 40
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [BCD_BITS-1:0] in_bcd,
   bda_rsp_if.source           rsp
);
   localparam int unsigned DIGITS = BCD_BITS / bda_pkg::DIGIT_BITS;
   localparam int unsigned IDX_BITS = $clog2(DIGITS);

   logic                busy_ff;
   logic [BCD_BITS-1:0] bcd_ff;
   logic [IDX_BITS-1:0] idx_ff;
   logic [IDX_BITS-1:0] top;
   logic                out_valid_ff;
   bda_pkg::char_type   char_ff;
   logic                last_ff;
   logic                emit;
   logic [3:0]          digit;

   assign in_ready = !busy_ff;
   assign emit = busy_ff && (!out_valid_ff || rsp.ready);
   assign digit = bcd_ff[idx_ff*4 +: 4];

   // highest nonzero digit, zero when the value is zero
   always_comb begin
      top = '0;
      for (int i = 0; i < DIGITS; i++) begin
         if (in_bcd[i*4 +: 4] != 4'd0) begin
            top = IDX_BITS'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_valid && !busy_ff) begin
            busy_ff <= 1'b1;
         end else if (emit && idx_ff == '0) begin
            busy_ff <= 1'b0;
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && !busy_ff) begin
         bcd_ff <= in_bcd;
         idx_ff <= top;
      end else if (emit) begin
         idx_ff <= idx_ff - 1'b1;
      end
      if (emit) begin
         char_ff <= bda_pkg::ASCII_ZERO + {2'b00, digit};
         last_ff <= (idx_ff == '0);
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.digit_char = char_ff;
   assign rsp.last = last_ff;
endmodule

// ===== hw/rtl/binary_to_decimal_ascii_core.sv =====
// Converts an unsigned value to decimal ascii digits, most significant first, leading
// zeros dropped, zero printed as a single '0', last set on the final digit. The value
// runs through a VALUE_BITS-stage shift-and-add-3 pipeline (one stage per input bit),
// then a serializer sends one char per beat. The serializer sets the rate: it takes
// no new item until the last digit of the current one is in its output register, while
// later items wait in the pipeline stages.
// depends on bda_pkg, bda_if, bda_dabble_stage and bda_serializer
module binary_to_decimal_ascii_core #(
   parameter int unsigned VALUE_BITS = 32
) (
   input logic       clock,
   input logic       reset,
   bda_req_if.sink   req_bus,
   bda_rsp_if.source rsp_bus
);
   localparam int unsigned DIGITS = (VALUE_BITS * 30103 + 99999) / 100000;
   localparam int unsigned BCD_BITS = DIGITS * bda_pkg::DIGIT_BITS;

   logic                  valid [VALUE_BITS+1];
   logic                  ready [VALUE_BITS+1];
   logic [BCD_BITS-1:0]   bcd   [VALUE_BITS+1];
   logic [VALUE_BITS-1:0] bin   [VALUE_BITS+1];

   generate
      if (VALUE_BITS <= bda_pkg::FIELD_BITS) begin : g_narrow
         assign bin[0] = req_bus.value[VALUE_BITS-1:0];
      end else begin : g_wide
         assign bin[0] = {{(VALUE_BITS - bda_pkg::FIELD_BITS){1'b0}}, req_bus.value};
      end
   endgenerate

   assign valid[0] = req_bus.valid;
   assign bcd[0] = '0;
   assign req_bus.ready = ready[0];

   for (genvar s = 0; s < VALUE_BITS; s++) begin : g_stage
      bda_dabble_stage #(
         .VALUE_BITS(VALUE_BITS),
         .BCD_BITS(BCD_BITS)
      ) u_stage (
         .clock(clock),
         .reset(reset),
         .in_valid(valid[s]),
         .in_ready(ready[s]),
         .in_bcd(bcd[s]),
         .in_bin(bin[s]),
         .out_valid(valid[s+1]),
         .out_ready(ready[s+1]),
         .out_bcd(bcd[s+1]),
         .out_bin(bin[s+1])
      );
   end

   bda_serializer #(
      .BCD_BITS(BCD_BITS)
   ) u_ser (
      .clock(clock),
      .reset(reset),
      .in_valid(valid[VALUE_BITS]),
      .in_ready(ready[VALUE_BITS]),
      .in_bcd(bcd[VALUE_BITS]),
      .rsp(rsp_bus)
   );
endmodule
